@@ rtl/cba_pkg.sv @@
// shared types and codes for the chained bump allocator
`default_nettype none
package cba_pkg;

	localparam int REQ_W = 17;
	localparam int ALIGN_W = 4;
	localparam int FILL_W = 17;
	localparam int NEED_W = 18;
	localparam int OFFSET_W = 16;
	localparam int PAGE_IDX_W = 3;
	localparam int PAGE_CNT_W = 3;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_RESET  = 1'b1
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_LOOK
	} state_t;

endpackage
`default_nettype wire

@@ rtl/cba_ram.sv @@
// generic single write port ram with registered read
`default_nettype none
module cba_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 5
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ rtl/chained_bump_allocator_unit.sv @@
// chained bump allocator top level: page fill memory and page search sequencer
// an insert tries k pages, one after another, from accept to result strobe (k = 1 to MAX_EXTRA_PAGES+1)
// one fill memory read per page visited sets the pace; busy stays high until the strobe cycle
// a reset-all word is done without leaving idle, strobe in the cycle after accept
// throughput: next word can be accepted in the strobe cycle; results cannot be stalled
// arst_n clears control state: one open page, primary page empty, overflow alignment 0
`default_nettype none
module chained_bump_allocator_unit #(
	parameter int PRIMARY_BYTES = 65536,
	parameter int OVERFLOW_BYTES = 65536,
	parameter int MAX_EXTRA_PAGES = 4
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic                           operation,
	input  wire logic [cba_pkg::REQ_W-1:0]      request_bytes,
	input  wire logic [cba_pkg::ALIGN_W-1:0]    align_log2,
	input  wire logic                           cfg_write,
	input  wire logic [cba_pkg::ALIGN_W-1:0]    cfg_data,
	output logic                                done,
	output logic                                ok,
	output logic      [cba_pkg::PAGE_IDX_W-1:0] page_index,
	output logic      [cba_pkg::OFFSET_W-1:0]   start_offset,
	output logic      [cba_pkg::PAGE_CNT_W-1:0] pages_in_use
);

	localparam int SLOTS = MAX_EXTRA_PAGES + 1;
	localparam int PW = $clog2(SLOTS);
	localparam int CW = $clog2(MAX_EXTRA_PAGES + 2);
	localparam int CW1 = CW + 1;
	localparam int FW = cba_pkg::FILL_W;
	localparam int NW = cba_pkg::NEED_W;
	localparam logic [FW-1:0] PRIM_SZ = FW'(PRIMARY_BYTES);
	localparam logic [FW-1:0] OVFL_SZ = FW'(OVERFLOW_BYTES);
	localparam logic [NW-1:0] OVFL_NEED = NW'(OVERFLOW_BYTES);
	localparam logic [PW-1:0] LAST_PAGE = PW'(MAX_EXTRA_PAGES);

	cba_pkg::state_t state_q, state_d;
	logic [PW-1:0]                   p_q, p_d;
	logic [CW-1:0]                   open_q, open_d;
	logic                            prim_vld_q, prim_vld_d;
	logic                            fresh_q, fresh_d;
	logic [cba_pkg::REQ_W-1:0]       req_q;
	logic [cba_pkg::ALIGN_W-1:0]     alg_q;
	logic [cba_pkg::ALIGN_W-1:0]     ovfl_align_q;
	logic                            done_q, done_d;
	logic                            ok_q, ok_d;
	logic [PW-1:0]                   page_q, page_d;
	logic [cba_pkg::OFFSET_W-1:0]    offset_q, offset_d;

	logic                            we;
	logic [PW-1:0]                   waddr;
	logic [FW-1:0]                   wdata;
	logic [PW-1:0]                   raddr;
	logic [FW-1:0]                   rdata;

	logic [cba_pkg::ALIGN_W-1:0]     lg;
	logic [NW-1:0]                   step;
	logic [NW-1:0]                   mask;
	logic [NW-1:0]                   req_ext;
	logic [NW-1:0]                   need;
	logic [FW-1:0]                   fill;
	logic [FW-1:0]                   room;
	logic [NW-1:0]                   new_fill;
	logic                            fits;
	logic                            has_next;
	logic                            is_last;

	cba_ram #(
		.WIDTH(FW),
		.DEPTH(SLOTS)
	) u_fill_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// rounding and room check for the page under test
	always_comb begin
		lg = (p_q == '0) ? alg_q : ovfl_align_q;
		step = NW'(1) << lg;
		mask = step - NW'(1);
		req_ext = NW'(req_q);
		need = ((req_ext & mask) != '0) ? ((req_ext & ~mask) + step) : req_ext;
		fill = (fresh_q || (p_q == '0 && !prim_vld_q)) ? '0 : rdata;
		room = ((p_q == '0) ? PRIM_SZ : OVFL_SZ) - fill;
		fits = need <= NW'(room);
		new_fill = NW'(fill) + need;
		has_next = (CW1'(p_q) + CW1'(1)) < CW1'(open_q);
		is_last = p_q == LAST_PAGE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cba_pkg::ST_IDLE;
			p_q <= '0;
			open_q <= CW'(1);
			prim_vld_q <= 1'b0;
			fresh_q <= 1'b0;
			ovfl_align_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			p_q <= p_d;
			open_q <= open_d;
			prim_vld_q <= prim_vld_d;
			fresh_q <= fresh_d;
			done_q <= done_d;
			if (cfg_write) begin
				ovfl_align_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && state_q == cba_pkg::ST_IDLE) begin
			req_q <= request_bytes;
			alg_q <= align_log2;
		end
		ok_q <= ok_d;
		page_q <= page_d;
		offset_q <= offset_d;
	end

	always_comb begin
		state_d = state_q;
		p_d = p_q;
		open_d = open_q;
		prim_vld_d = prim_vld_q;
		fresh_d = fresh_q;
		done_d = 1'b0;
		ok_d = ok_q;
		page_d = page_q;
		offset_d = offset_q;
		we = 1'b0;
		waddr = p_q;
		wdata = FW'(new_fill);
		raddr = is_last ? p_q : p_q + PW'(1);
		unique case (state_q)
			cba_pkg::ST_IDLE: begin
				raddr = '0;
				if (start) begin
					if (operation == cba_pkg::OP_RESET) begin
						open_d = CW'(1);
						prim_vld_d = 1'b0;
						done_d = 1'b1;
						ok_d = 1'b1;
						page_d = '0;
						offset_d = '0;
					end else begin
						state_d = cba_pkg::ST_LOOK;
						p_d = '0;
						fresh_d = 1'b0;
					end
				end
			end
			cba_pkg::ST_LOOK: begin
				if (fits) begin
					we = 1'b1;
					if (p_q == '0) begin
						prim_vld_d = 1'b1;
					end
					done_d = 1'b1;
					ok_d = 1'b1;
					page_d = p_q;
					offset_d = fill[cba_pkg::OFFSET_W-1:0];
					state_d = cba_pkg::ST_IDLE;
				end else if (has_next) begin
					p_d = p_q + PW'(1);
					fresh_d = 1'b0;
				end else if (is_last || need > OVFL_NEED) begin
					done_d = 1'b1;
					ok_d = 1'b0;
					page_d = '0;
					offset_d = '0;
					state_d = cba_pkg::ST_IDLE;
				end else begin
					// open a new overflow page, cleared in memory
					p_d = p_q + PW'(1);
					open_d = CW'(p_q) + CW'(2);
					fresh_d = 1'b1;
					we = 1'b1;
					waddr = p_q + PW'(1);
					wdata = '0;
				end
			end
			default: begin
				state_d = cba_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = state_q != cba_pkg::ST_IDLE;
	assign done = done_q;
	assign ok = ok_q;
	assign page_index = cba_pkg::PAGE_IDX_W'(page_q);
	assign start_offset = offset_q;
	assign pages_in_use = cba_pkg::PAGE_CNT_W'(open_q);

endmodule
`default_nettype wire

@@ rtl/cba_checker.sv @@
// port level checks for the chained bump allocator, bound to the top level
`default_nettype none
module cba_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           start,
	input wire logic                           busy,
	input wire logic                           operation,
	input wire logic                           done,
	input wire logic                           ok,
	input wire logic [cba_pkg::PAGE_IDX_W-1:0] page_index,
	input wire logic [cba_pkg::OFFSET_W-1:0]   start_offset,
	input wire logic [cba_pkg::PAGE_CNT_W-1:0] pages_in_use
);

	// reset-all word answers next cycle with one page open
	a_reset_word: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && operation == cba_pkg::OP_RESET |=>
		done && ok && page_index == '0 && start_offset == '0 &&
		pages_in_use == cba_pkg::PAGE_CNT_W'(1))
		else $error("reset word result wrong");

	// a failed insert reports page zero, offset zero
	a_fail_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && !ok |-> page_index == '0 && start_offset == '0)
		else $error("failed insert with nonzero page or offset");

	// an accepted word either finishes at once or keeps the unit busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted word neither busy nor done");

	// the result strobe comes only once the unit is free again
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

endmodule

bind chained_bump_allocator_unit cba_checker u_cba_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.operation   (operation),
	.done        (done),
	.ok          (ok),
	.page_index  (page_index),
	.start_offset(start_offset),
	.pages_in_use(pages_in_use)
);
`default_nettype wire
